// ===== hdl/ascii_rtcm_frame_detector_macros.svh =====
// Assertion macros shared by the frame detector RTL.
`ifndef ASCII_RTCM_FRAME_DETECTOR_MACROS_SVH
`define ASCII_RTCM_FRAME_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARDET_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARDET_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ardet_pkg.sv =====
// Package: constants and types of the ASCII / RTCM3 frame detector.
`default_nettype none
package ardet_pkg;

  typedef enum logic [1:0] {
    FRAME_NONE  = 2'd0,
    FRAME_ASCII = 2'd1,
    FRAME_RTCM  = 2'd2
  } frame_status_t;

  // CRC unit control for one byte transfer
  typedef struct packed {
    logic advance;  // a byte moves through this cycle
    logic restart;  // byte opens a frame: start from zero
    logic update;   // fold the byte into the CRC
    logic clear;    // frame ends or is rejected: zero the CRC
  } crc_ctrl_t;

  localparam logic [23:0] CRC24Q_POLY   = 24'h864CFB;
  localparam logic [7:0]  RTCM_PREAMBLE = 8'hD3;
  localparam logic [7:0]  CHAR_HASH     = 8'h23;
  localparam logic [7:0]  CHAR_A        = 8'h41;
  localparam logic [7:0]  CHAR_P        = 8'h50;
  localparam logic [7:0]  CHAR_STAR     = 8'h2A;
  localparam logic [7:0]  CHAR_COMMA    = 8'h2C;
  localparam logic [7:0]  CHAR_CR       = 8'h0D;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;
  localparam logic [11:0] MSG_TYPE_SUB  = 12'd4058;
  localparam int          CRC_BYTES     = 3;

endpackage
`default_nettype wire

// ===== hdl/ardet_crc24q.sv =====
// CRC-24Q register with a one-byte-per-cycle MSB-first update, taken while ctrl.advance is high.
`default_nettype none
module ardet_crc24q (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ardet_pkg::crc_ctrl_t ctrl,
  input  wire logic [7:0]           data,
  output logic [23:0]               crc
);

  logic [23:0] base;
  logic [23:0] crc_next;

  function automatic logic [23:0] crc_byte(input logic [23:0] c, input logic [7:0] d);
    logic [23:0] r;
    r = c ^ {d, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      r = {r[22:0], 1'b0} ^ (r[23] ? ardet_pkg::CRC24Q_POLY : 24'h000000);
    end
    return r;
  endfunction

  always_comb begin
    base = ctrl.restart ? 24'h000000 : crc;
    if (ctrl.clear) begin
      crc_next = 24'h000000;
    end else if (ctrl.update) begin
      crc_next = crc_byte(base, data);
    end else begin
      crc_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 24'h000000;
    end else if (ctrl.advance) begin
      crc <= crc_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ascii_rtcm_frame_detector.sv =====
// Top level: byte-serial detector for '#AP' ASCII sentences and RTCM3 frames.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | rx_byte
//  result  | out       | out_valid / out_ready| frame_status, byte_stored, byte_position,
//          |           |                      | is_separator, separator_count, frame_length,
//          |           |                      | crc_error, message_type, message_subtype
//
// One byte per cycle sustained while out_ready stays high. A byte is held in the input
// register, then the frame checks, separator count and CRC-24Q byte update run in one
// pass into the result register, which raises out_valid.
// Reset (rst, synchronous) empties both registers and clears all frame state.
// A stalled result holds the pipe; the input register takes a byte while it is empty or
// hands its byte on in the same cycle, so in_ready drops only with both registers full.
`default_nettype none
module ascii_rtcm_frame_detector #(
  parameter int BUFFER_BYTES   = 2048,
  parameter int MAX_SEPARATORS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       frame_status,
  output logic             byte_stored,
  output logic [10:0]      byte_position,
  output logic             is_separator,
  output logic [6:0]       separator_count,
  output logic [11:0]      frame_length,
  output logic             crc_error,
  output logic [11:0]      message_type,
  output logic [3:0]       message_subtype
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);   // byte counter width
  localparam int SW = $clog2(MAX_SEPARATORS + 1); // separator counter width

  // input register
  logic       s0_valid;
  logic [7:0] s0_byte;
  logic       adv;

  // frame state
  logic [CW-1:0] byte_count;
  logic [7:0]    first_b0;
  logic [7:0]    first_b1;
  logic [23:0]   recent_bytes;
  logic [10:0]   payload_length;   // header + payload size n
  logic [SW-1:0] sep_counter;
  logic [15:0]   type_word;
  logic [23:0]   parity_word;
  logic [23:0]   running_crc;

  logic [CW-1:0] byte_count_next;
  logic [7:0]    first_b0_next;
  logic [7:0]    first_b1_next;
  logic [23:0]   recent_bytes_next;
  logic [10:0]   payload_length_next;
  logic [SW-1:0] sep_counter_next;
  logic [15:0]   type_word_next;
  logic [23:0]   parity_word_next;

  // per-byte decode
  logic          limit_hit;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_inc;
  logic [12:0]   pos_w;
  logic [12:0]   len_w;
  logic          is_rtcm;
  logic          reject;
  logic          in_header;
  logic          sep_hit;
  logic          rtcm_in_crc;
  logic          frame_done;

  ardet_pkg::crc_ctrl_t     crc_ctrl;
  ardet_pkg::frame_status_t res_status;
  logic                     res_sep;
  logic                     res_err;
  logic [11:0]              res_type;
  logic [3:0]               res_sub;

  assign adv      = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_byte <= rx_byte;
    end
  end

  // A full buffer drops the frame; the byte is then looked at as a start byte.
  assign limit_hit = byte_count >= CW'(BUFFER_BYTES);
  assign pos       = limit_hit ? '0 : byte_count;
  assign pos_inc   = pos + CW'(1);
  assign pos_w     = 13'(pos);
  assign len_w     = 13'(payload_length);
  assign is_rtcm   = first_b0 == ardet_pkg::RTCM_PREAMBLE;
  assign in_header = pos < CW'(ardet_pkg::CRC_BYTES);

  // start pattern: '#','A','P' or 0xD3 followed by any two bytes
  always_comb begin
    reject = 1'b0;
    if (pos == '0) begin
      reject = (s0_byte != ardet_pkg::CHAR_HASH) && (s0_byte != ardet_pkg::RTCM_PREAMBLE);
    end else if (pos == CW'(1)) begin
      reject = !((s0_byte == ardet_pkg::CHAR_A && first_b0 == ardet_pkg::CHAR_HASH)
                 || is_rtcm);
    end else if (pos == CW'(2)) begin
      reject = !((s0_byte == ardet_pkg::CHAR_P && first_b1 == ardet_pkg::CHAR_A
                  && first_b0 == ardet_pkg::CHAR_HASH) || is_rtcm);
    end
  end

  always_comb begin
    // values the frame carries in; a fresh frame starts from zero
    first_b0_next       = (pos == '0) ? s0_byte : first_b0;
    first_b1_next       = (pos == '0) ? 8'h00 : ((pos == CW'(1)) ? s0_byte : first_b1);
    recent_bytes_next   = (pos == '0) ? {16'h0000, s0_byte}
                                      : {recent_bytes[15:0], s0_byte};
    payload_length_next = (pos == '0) ? 11'd0 : payload_length;
    sep_counter_next    = (pos == '0) ? '0 : sep_counter;
    type_word_next      = (pos == '0) ? 16'h0000 : type_word;
    parity_word_next    = (pos == '0) ? 24'h000000 : parity_word;
    byte_count_next     = pos_inc;

    sep_hit     = 1'b0;
    rtcm_in_crc = 1'b0;
    frame_done  = 1'b0;
    res_status  = ardet_pkg::FRAME_NONE;
    res_sep     = 1'b0;
    res_err     = 1'b0;
    res_type    = 12'h000;
    res_sub     = 4'h0;

    if (in_header) begin
      if (pos == CW'(2) && is_rtcm) begin
        payload_length_next = {1'b0, first_b1[1:0], s0_byte} + 11'd3;
      end
    end else if (!is_rtcm) begin
      // ASCII body: a comma is a separator; CR/LF with '*' three bytes back is one too and ends the sentence
      if (s0_byte == ardet_pkg::CHAR_COMMA) begin
        sep_hit = 1'b1;
      end
      if ((s0_byte == ardet_pkg::CHAR_CR || s0_byte == ardet_pkg::CHAR_LF)
          && recent_bytes[23:16] == ardet_pkg::CHAR_STAR) begin
        sep_hit    = 1'b1;
        frame_done = 1'b1;
        res_status = ardet_pkg::FRAME_ASCII;
      end
      res_sep = sep_hit;
      if (sep_hit && sep_counter < SW'(MAX_SEPARATORS)) begin
        sep_counter_next = sep_counter + SW'(1);
      end
    end else begin
      // RTCM body: type word from bytes 3..4, CRC up to n, parity after
      if (pos == CW'(3) || pos == CW'(4)) begin
        type_word_next = {type_word[7:0], s0_byte};
      end
      if (pos_w < len_w) begin
        rtcm_in_crc = 1'b1;
      end else begin
        parity_word_next = {parity_word[15:0], s0_byte};
      end
      if (pos_w >= len_w + 13'd2) begin
        frame_done = 1'b1;
        res_status = ardet_pkg::FRAME_RTCM;
        res_err    = running_crc != parity_word_next;
        res_type   = type_word_next[15:4];
        if (!res_err && res_type == ardet_pkg::MSG_TYPE_SUB) begin
          res_sub = type_word_next[3:0];
        end
      end
    end
  end

  assign crc_ctrl.advance = adv;
  assign crc_ctrl.restart = pos == '0;
  assign crc_ctrl.update  = in_header || rtcm_in_crc;
  assign crc_ctrl.clear   = reject || frame_done;

  ardet_crc24q u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .data (s0_byte),
    .crc  (running_crc)
  );

  // frame state: cleared on reject and after a completed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      first_b0       <= 8'h00;
      first_b1       <= 8'h00;
      recent_bytes   <= 24'h000000;
      payload_length <= 11'd0;
      sep_counter    <= '0;
      type_word      <= 16'h0000;
      parity_word    <= 24'h000000;
    end else if (adv) begin
      if (reject || frame_done) begin
        byte_count     <= '0;
        first_b0       <= 8'h00;
        first_b1       <= 8'h00;
        recent_bytes   <= 24'h000000;
        payload_length <= 11'd0;
        sep_counter    <= '0;
        type_word      <= 16'h0000;
        parity_word    <= 24'h000000;
      end else begin
        byte_count     <= byte_count_next;
        first_b0       <= first_b0_next;
        first_b1       <= first_b1_next;
        recent_bytes   <= recent_bytes_next;
        payload_length <= payload_length_next;
        sep_counter    <= sep_counter_next;
        type_word      <= type_word_next;
        parity_word    <= parity_word_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (reject) begin
        // rejected byte: all-zero result
        frame_status    <= ardet_pkg::FRAME_NONE;
        byte_stored     <= 1'b0;
        byte_position   <= 11'd0;
        is_separator    <= 1'b0;
        separator_count <= 7'd0;
        frame_length    <= 12'd0;
        crc_error       <= 1'b0;
        message_type    <= 12'h000;
        message_subtype <= 4'h0;
      end else begin
        frame_status    <= res_status;
        byte_stored     <= 1'b1;
        byte_position   <= 11'(pos);
        is_separator    <= res_sep;
        separator_count <= 7'(sep_counter_next);
        frame_length    <= 12'(pos_inc);
        crc_error       <= res_err;
        message_type    <= res_type;
        message_subtype <= res_sub;
      end
    end
  end

`include "ascii_rtcm_frame_detector_macros.svh"

  `ARDET_ASSERT_IMP(a_done_is_stored, clk, rst, out_valid && frame_status != ardet_pkg::FRAME_NONE, byte_stored, "completed frame on a byte not stored")
  `ARDET_ASSERT_IMP(a_reject_zero, clk, rst, out_valid && !byte_stored, frame_length == 12'd0 && separator_count == 7'd0 && !is_separator, "rejected byte with nonzero result")
  `ARDET_ASSERT_IMP(a_rtcm_fields, clk, rst, out_valid && frame_status != ardet_pkg::FRAME_RTCM, !crc_error && message_type == 12'h000 && message_subtype == 4'h0, "RTCM fields set outside RTCM completion")
  `ARDET_ASSERT_NEXT(a_clear_after_frame, clk, rst, adv && (frame_done || reject), byte_count == '0 && running_crc == 24'h000000, "frame state not cleared")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the ASCII / RTCM3 frame detector: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;

  localparam int BUFFER_BYTES   = 2048;
  localparam int MAX_SEPARATORS = 64;

  // One result transfer as the detector should present it.
  typedef struct {
    ardet_pkg::frame_status_t status;
    logic          stored;
    logic [10:0]   position;
    logic          sep;
    logic [6:0]    sep_count;
    logic [11:0]   length;
    logic          crc_err;
    logic [11:0]   msg_type;
    logic [3:0]    msg_sub;
  } byte_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_status;
  logic        byte_stored;
  logic [10:0] byte_position;
  logic        is_separator;
  logic [6:0]  separator_count;
  logic [11:0] frame_length;
  logic        crc_error;
  logic [11:0] message_type;
  logic [3:0]  message_subtype;

  ascii_rtcm_frame_detector #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .MAX_SEPARATORS(MAX_SEPARATORS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_status   (frame_status),
    .byte_stored    (byte_stored),
    .byte_position  (byte_position),
    .is_separator   (is_separator),
    .separator_count(separator_count),
    .frame_length   (frame_length),
    .crc_error      (crc_error),
    .message_type   (message_type),
    .message_subtype(message_subtype)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  logic [7:0]   pending_bytes[$];   // bytes waiting for the input driver
  byte_report_t due_reports[$];     // predicted results, oldest first
  int           send_idle_pct  = 0; // chance the sender leaves a cycle empty
  int           recv_stall_pct = 0; // chance the receiver drops out_ready
  logic         in_took = 1'b0;     // input transfer at the last rising edge
  int           errors = 0;
  int           n_results = 0;

  // Frame tracker: mirrors the detector's frame state byte by byte.
  int unsigned  tr_count;    // bytes stored in the current frame
  logic [23:0]  tr_head;     // first three bytes
  logic [23:0]  tr_recent;   // last three stored bytes
  logic [23:0]  tr_crc;      // running CRC-24Q
  int unsigned  tr_len;      // RTCM header plus payload size
  logic [6:0]   tr_seps;     // separators counted so far
  logic [15:0]  tr_type;     // RTCM bytes 3 and 4
  logic [23:0]  tr_parity;   // bytes at or past the payload end

  // coverage tallies for the closing summary
  int n_sentences = 0, n_frames = 0, n_crc_bad = 0, n_subtypes = 0;
  int n_rejects = 0, n_drops = 0, n_sep_sat = 0;

  // CRC-24Q over one byte, MSB first, polynomial 0x864CFB.
  function automatic logic [23:0] crc24q_byte(logic [23:0] c, logic [7:0] b);
    c ^= {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      c = c[23] ? ((c << 1) ^ ardet_pkg::CRC24Q_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void clear_track();
    tr_count  = 0;
    tr_head   = '0;
    tr_recent = '0;
    tr_crc    = '0;
    tr_len    = 0;
    tr_seps   = '0;
    tr_type   = '0;
    tr_parity = '0;
  endfunction

  function automatic void bump_separators();
    if (tr_seps < MAX_SEPARATORS) tr_seps++;
    else n_sep_sat++;
  endfunction

  // Advance the tracker by one accepted byte and return the result it causes.
  function automatic byte_report_t track_byte(logic [7:0] d);
    byte_report_t r;
    int unsigned  pos;
    logic [7:0]   b0, b1;
    r = '{ardet_pkg::FRAME_NONE, 1'b0, 11'd0, 1'b0, 7'd0, 12'd0, 1'b0, 12'd0, 4'd0};

    // frame ran into the buffer limit: drop it, byte is looked at as a start
    if (tr_count >= BUFFER_BYTES) begin
      clear_track();
      n_drops++;
    end
    pos = tr_count;
    b0  = tr_head[23:16];
    b1  = tr_head[15:8];

    // start pattern check; a misfit byte is dropped, not retried as a start
    if ((pos == 0 && d != ardet_pkg::CHAR_HASH && d != ardet_pkg::RTCM_PREAMBLE) ||
        (pos == 1 && !((d == ardet_pkg::CHAR_A && b0 == ardet_pkg::CHAR_HASH) ||
                       b0 == ardet_pkg::RTCM_PREAMBLE)) ||
        (pos == 2 && !((d == ardet_pkg::CHAR_P && b1 == ardet_pkg::CHAR_A &&
                        b0 == ardet_pkg::CHAR_HASH) ||
                       b0 == ardet_pkg::RTCM_PREAMBLE))) begin
      clear_track();
      n_rejects++;
      return r;
    end

    if (pos < 3) begin
      tr_head[23 - 8 * pos -: 8] = d;
      tr_crc = crc24q_byte(tr_crc, d);
      if (pos == 2 && b0 == ardet_pkg::RTCM_PREAMBLE) tr_len = {b1[1:0], d} + 3;
    end else if (b0 != ardet_pkg::RTCM_PREAMBLE) begin
      // ASCII sentence body
      if (d == ardet_pkg::CHAR_COMMA) begin
        r.sep = 1'b1;
        bump_separators();
      end
      if ((d == ardet_pkg::CHAR_CR || d == ardet_pkg::CHAR_LF) &&
          tr_recent[23:16] == ardet_pkg::CHAR_STAR) begin
        r.sep    = 1'b1;
        bump_separators();
        r.status = ardet_pkg::FRAME_ASCII;
        n_sentences++;
      end
    end else begin
      // RTCM3 body: type word, CRC over header and payload, then parity
      if (pos == 3 || pos == 4) tr_type = {tr_type[7:0], d};
      if (pos < tr_len) tr_crc = crc24q_byte(tr_crc, d);
      else tr_parity = {tr_parity[15:0], d};
      if (pos + 1 >= tr_len + 3) begin
        r.status   = ardet_pkg::FRAME_RTCM;
        r.crc_err  = (tr_crc != tr_parity);
        r.msg_type = tr_type[15:4];
        if (!r.crc_err && r.msg_type == ardet_pkg::MSG_TYPE_SUB) begin
          r.msg_sub = tr_type[3:0];
          n_subtypes++;
        end
        n_frames++;
        if (r.crc_err) n_crc_bad++;
      end
    end

    tr_recent   = {tr_recent[15:0], d};
    tr_count    = pos + 1;
    r.stored    = 1'b1;
    r.position  = 11'(pos);
    r.sep_count = tr_seps;
    r.length    = 12'(tr_count);
    if (r.status != ardet_pkg::FRAME_NONE) clear_track();
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, n_results, what, got,
             want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next byte at the falling edge, toggles out_ready.
  // A new byte goes out only when the line is empty or the last one transferred.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each result transfer.
  // The result register lies behind the input register, so the push never races the matching pop.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_report_t want;
    in_took <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) due_reports.push_back(track_byte(rx_byte));
      if (out_valid && out_ready) begin
        n_results++;
        if (due_reports.size() == 0) begin
          $display("[%0t] result %0d arrived with nothing outstanding", $realtime,
                   n_results);
          errors++;
        end else begin
          want = due_reports.pop_front();
          if (frame_status !== want.status)
            report_mismatch("frame_status", frame_status, want.status);
          if (byte_stored !== want.stored)
            report_mismatch("byte_stored", byte_stored, want.stored);
          if (byte_position !== want.position)
            report_mismatch("byte_position", byte_position, want.position);
          if (is_separator !== want.sep)
            report_mismatch("is_separator", is_separator, want.sep);
          if (separator_count !== want.sep_count)
            report_mismatch("separator_count", separator_count, want.sep_count);
          if (frame_length !== want.length)
            report_mismatch("frame_length", frame_length, want.length);
          if (crc_error !== want.crc_err)
            report_mismatch("crc_error", crc_error, want.crc_err);
          if (message_type !== want.msg_type)
            report_mismatch("message_type", message_type, want.msg_type);
          if (message_subtype !== want.msg_sub)
            report_mismatch("message_subtype", message_subtype, want.msg_sub);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  // RTCM3 frame with a given payload length; type and subtype fill the first
  // payload bytes. corrupt flips one bit past the length field.
  task automatic push_rtcm_frame(int unsigned len, logic [11:0] mtype, logic [3:0] sub,
                                 bit corrupt);
    logic [7:0]  frame[$];
    logic [23:0] crc;
    int unsigned at;
    frame.push_back(ardet_pkg::RTCM_PREAMBLE);
    frame.push_back({6'($urandom_range(63)), 2'(len >> 8)});
    frame.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == 0) frame.push_back(mtype[11:4]);
      else if (i == 1) frame.push_back({mtype[3:0], sub});
      else frame.push_back(8'($urandom_range(255)));
    end
    crc = '0;
    foreach (frame[i]) crc = crc24q_byte(crc, frame[i]);
    frame.push_back(crc[23:16]);
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    if (corrupt) begin
      at = $urandom_range(frame.size() - 1, 3);
      frame[at] ^= 8'(1 << $urandom_range(7));
    end
    foreach (frame[i]) pending_bytes.push_back(frame[i]);
  endtask

  // Wait until every queued byte has transferred and every result has come.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || due_reports.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, four phases with differing idle and stall chances, drain, verdict.
  // Each phase ends with a full drain, so the sender sits idle until every
  // predicted result is back before the next phase starts.
  // ---------------------------------------------------------------------------
  initial begin
    int          counted;
    int          r, body;
    int unsigned len;
    logic [11:0] mtype;
    clear_track();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase

      if (phase == 0) begin
        // extremes and early rejects at each header position
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        push_text("#X");
        push_text("#AQ");
        // shortest sentence with a comma, star-terminated on CR
        push_text("#AP,*ab\r");
        // zero-length RTCM: type word is read from the parity bytes
        push_rtcm_frame(0, 12'd0, 4'd0, 1'b0);
        // subtype-bearing message, all-ones subtype
        push_rtcm_frame(2, ardet_pkg::MSG_TYPE_SUB, 4'hF, 1'b0);
      end
      if (phase == 1) begin
        // sentence with more commas than the separator counter holds
        push_text("#AP");
        repeat (70) pending_bytes.push_back(ardet_pkg::CHAR_COMMA);
        push_text("*12\n");
      end

      counted = 0;
      while (counted < 250) begin
        r = $urandom_range(99);
        if (r < 42) begin
          // ASCII sentence with random body; most end properly
          push_text("#AP");
          body = $urandom_range(24);
          for (int i = 0; i < body; i++) begin
            r = $urandom_range(99);
            if (r < 20) pending_bytes.push_back(ardet_pkg::CHAR_COMMA);
            else if (r < 25) pending_bytes.push_back(ardet_pkg::CHAR_STAR);
            else if (r < 32) pending_bytes.push_back(8'($urandom_range(255)));
            else pending_bytes.push_back(8'($urandom_range(90, 48)));
          end
          counted += body + 3;
          if ($urandom_range(99) < 85) begin
            pending_bytes.push_back(ardet_pkg::CHAR_STAR);
            pending_bytes.push_back(8'($urandom_range(57, 48)));
            pending_bytes.push_back(8'($urandom_range(70, 65)));
            pending_bytes.push_back($urandom_range(1) ? ardet_pkg::CHAR_CR
                                                      : ardet_pkg::CHAR_LF);
            counted += 4;
          end
        end else if (r < 80) begin
          // RTCM3 frame; short lengths dominate
          r = $urandom_range(99);
          if (r < 12) len = $urandom_range(1);
          else if (r < 80) len = $urandom_range(20, 2);
          else len = $urandom_range(80, 21);
          mtype = ($urandom_range(99) < 35) ? ardet_pkg::MSG_TYPE_SUB
                                            : 12'($urandom_range(4095));
          push_rtcm_frame(len, mtype, 4'($urandom_range(15)), $urandom_range(99) < 15);
          counted += len + 6;
        end else if (r < 92) begin
          // line noise
          repeat ($urandom_range(4, 1)) pending_bytes.push_back(8'($urandom_range(255)));
        end else begin
          // broken ASCII header followed by junk
          if ($urandom_range(1)) push_text("#");
          else push_text("#A");
          pending_bytes.push_back(8'($urandom_range(255)));
        end
      end
      drain();
    end

    // let any stray late result show up before the verdict
    repeat (8) @(posedge clk);
    $display("Checked %0d results: %0d sentences, %0d RTCM frames (%0d CRC errors, %0d subtypes),",
             n_results, n_sentences, n_frames, n_crc_bad, n_subtypes);
    $display("%0d rejected bytes, %0d buffer-limit drops, %0d separators past saturation.",
             n_rejects, n_drops, n_sep_sat);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding", due_reports.size());
    $display("FAIL");
    $finish;
  end

endmodule
